@@ hw/rtl/gnms_pkg.sv @@
// gnms_pkg: shared types, constants and table functions for the gradient
// non-maximum suppression core. No dependencies.
`default_nettype none

package gnms_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int R         = 2;
  localparam int WSZ       = 2 * R + 1;
  localparam int NLINES    = 2 * R;
  localparam int NUM_DIRS  = 16;
  localparam int QDEPTH    = 8;
  localparam int GRAD_LIMIT = 255;

  // tangents of 11.25 and 33.75 degrees, 24 fraction bits
  localparam int TAN_SHIFT = 24;
  localparam logic [31:0] TAN_LO = 32'd3337196;
  localparam logic [31:0] TAN_HI = 32'd11210177;

  // register indexes on the apb port
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_BRIGHT_LINE = 1'b1;

  localparam logic [10:0] IMAGE_WIDTH_RST = 11'd640;

  typedef struct packed {
    logic signed [8:0] gx;
    logic signed [8:0] gy;
    logic [15:0]       norm;
  } pix_t;

  typedef pix_t [NLINES-1:0] line_t;

  typedef struct packed {
    logic [9:0]  col;
    logic [11:0] row;
    logic [3:0]  sector;
    logic [3:0]  beat_near;
    logic [7:0]  beat_far;
    logic [7:0]  dot_pos;
  } item_t;

  // compass direction m, counterclockwise in steps of 45 degrees
  function automatic int dir_dx(int m);
    int t [8];
    t = '{1, 1, 0, -1, -1, -1, 0, 1};
    return t[m];
  endfunction

  function automatic int dir_dy(int m);
    int t [8];
    t = '{0, 1, 1, 1, 0, -1, -1, -1};
    return t[m];
  endfunction

  // far offset: two steps on the axes, one on the diagonals
  function automatic int far_mul(int m);
    return (m % 2 == 0) ? 2 : 1;
  endfunction

  // offset lexicographically positive
  function automatic logic lex_pos(int m);
    return (dir_dx(m) > 0) || (dir_dx(m) == 0 && dir_dy(m) > 0);
  endfunction

  function automatic logic beats(logic [15:0] n0, logic [15:0] n, logic lex);
    return (n0 < n) || ((n0 == n) && lex);
  endfunction

  function automatic logic signed [8:0] sat_grad(logic signed [8:0] g);
    logic signed [8:0] lim;
    lim = 9'(GRAD_LIMIT);
    if (g > lim) return lim;
    else if (g < -lim) return -lim;
    else return g;
  endfunction

  // directions inside the opening of sector k
  function automatic logic [7:0] incl_mask(logic [3:0] k);
    logic [7:0] r;
    logic [3:0] d;
    r = '0;
    for (int m = 0; m < 8; m++) begin
      d = 4'(2 * m) - k;
      r[m] = (d <= 4'd2) || (d >= 4'd14);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gradient_nonmax_suppression_core.sv @@
// gradient_nonmax_suppression_core: top level with apb registers, front,
// queue and back. Depends on gnms_pkg, gnms_front, gnms_queue, gnms_back.
//
//   channel  direction  handshake                payload
//   in       sink       in_valid_i / in_stall_o  grad_x, grad_y, grad_norm, frame_start
//   out      source     out_valid_o / out_stall_i center_col, center_row, is_max
//   apb      sink       psel / penable / pready  image_width (0x0), bright_line (0x4)
//
// one pixel per clock when the output is not stalled; a result leaves after its
// pixel passes through line ram read, window, compares, sector and output register
// the eight-entry queue counts pixels still in the front pipeline, so the input
// stalls only when the queue and those pixels together fill it
// reset clears counters, window and queue; the line ram is not cleared
`default_nettype none

module gradient_nonmax_suppression_core #(
  parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  input  wire logic signed [8:0] grad_x_i,
  input  wire logic signed [8:0] grad_y_i,
  input  wire logic [15:0]       grad_norm_i,
  input  wire logic              frame_start_i,
  output      logic              out_valid_o,
  input  wire logic              out_stall_i,
  output      logic [9:0]        center_col_o,
  output      logic [11:0]       center_row_o,
  output      logic              is_max_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output      logic [31:0]       prdata,
  output      logic              pready
);

  localparam int QLW = $clog2(gnms_pkg::QDEPTH + 1);

  logic [10:0] image_width_q;
  logic        bright_line_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q <= gnms_pkg::IMAGE_WIDTH_RST;
      bright_line_q <= 1'b0;
    end else if (wr) begin
      unique case (paddr[2])
        gnms_pkg::REG_IMAGE_WIDTH: image_width_q <= pwdata[10:0];
        gnms_pkg::REG_BRIGHT_LINE: bright_line_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      gnms_pkg::REG_IMAGE_WIDTH: prdata = 32'(image_width_q);
      gnms_pkg::REG_BRIGHT_LINE: prdata = 32'(bright_line_q);
      default:                   prdata = '0;
    endcase
  end

  logic            push, pop, q_valid;
  gnms_pkg::item_t push_item, head_item;
  logic [QLW-1:0]  q_level;

  gnms_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .grad_x_i      (grad_x_i),
    .grad_y_i      (grad_y_i),
    .grad_norm_i   (grad_norm_i),
    .frame_start_i (frame_start_i),
    .image_width_i (image_width_q),
    .q_level_i     (q_level),
    .push_o        (push),
    .item_o        (push_item)
  );

  gnms_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item),
    .level_o (q_level)
  );

  gnms_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .item_i        (head_item),
    .pop_o         (pop),
    .bright_line_i (bright_line_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .center_col_o  (center_col_o),
    .center_row_o  (center_row_o),
    .is_max_o      (is_max_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/gnms_ram.sv @@
// gnms_ram: generic single write port, single read port ram with
// registered read data. No dependencies.
`default_nettype none

module gnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hw/rtl/gnms_front.sv @@
// gnms_front: pixel intake, raster counters, line buffer, window and
// per-center classification (sector, neighbor compares, dot signs).
// Depends on gnms_pkg and gnms_ram.
`default_nettype none

module gnms_front #(
  parameter int MAX_WIDTH = gnms_pkg::MAX_WIDTH
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic signed [8:0]    grad_x_i,
  input  wire logic signed [8:0]    grad_y_i,
  input  wire logic [15:0]          grad_norm_i,
  input  wire logic                 frame_start_i,
  input  wire logic [10:0]          image_width_i,
  input  wire logic [$clog2(gnms_pkg::QDEPTH+1)-1:0] q_level_i,
  output      logic                 push_o,
  output      gnms_pkg::item_t      item_o
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int XW  = (AW + 2 > 12) ? AW + 2 : 12;
  localparam int QLW = $clog2(gnms_pkg::QDEPTH + 1);
  localparam int LW  = $bits(gnms_pkg::line_t);

  // intake
  logic          accept;
  logic [AW-1:0] col0;
  logic [11:0]   row0;
  logic [XW-1:0] width_eff;
  logic          wrap;
  logic          emit0;
  gnms_pkg::pix_t px0;
  logic [AW-1:0] col_q, col_d;
  logic [11:0]   row_q, row_d;
  logic [QLW:0]  level;

  assign level = (QLW + 1)'(q_level_i) + (QLW + 1)'(e1_q) + (QLW + 1)'(e2_q)
               + (QLW + 1)'(e3_q);
  assign in_stall_o = level >= (QLW + 1)'(gnms_pkg::QDEPTH);
  assign accept = in_valid_i & ~in_stall_o;

  assign col0 = frame_start_i ? '0 : col_q;
  assign row0 = frame_start_i ? '0 : row_q;
  assign emit0 = (col0 >= AW'(gnms_pkg::NLINES)) && (row0 >= 12'(gnms_pkg::NLINES));

  always_comb begin
    width_eff = XW'(image_width_i);
    if (width_eff == '0) width_eff = XW'(1);
    if (width_eff > XW'(MAX_WIDTH)) width_eff = XW'(MAX_WIDTH);
  end
  assign wrap = (XW'(col0) + XW'(1)) >= width_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (wrap) begin
        col_d = '0;
        row_d = row0 + 12'd1;
      end else begin
        col_d = col0 + AW'(1);
        row_d = row0;
      end
    end
  end

  assign px0.gx   = gnms_pkg::sat_grad(grad_x_i);
  assign px0.gy   = gnms_pkg::sat_grad(grad_y_i);
  assign px0.norm = grad_norm_i;

  // stage 1: line buffer read data arrives
  logic            v1_q, e1_q, byp_q;
  gnms_pkg::pix_t  px1_q;
  logic [AW-1:0]   col1_q;
  logic [11:0]     row1_q;
  gnms_pkg::line_t rdata, ent, wdata, wdata_q;

  gnms_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (v1_q),
    .waddr_i (col1_q),
    .wdata_i (wdata),
    .raddr_i (col0),
    .rdata_o (rdata)
  );

  assign ent = byp_q ? wdata_q : rdata;

  always_comb begin
    for (int i = 0; i < gnms_pkg::NLINES - 1; i++) begin
      wdata[i] = ent[i+1];
    end
    wdata[gnms_pkg::NLINES-1] = px1_q;
  end

  // window, center at [R][R]
  gnms_pkg::pix_t win_q [gnms_pkg::WSZ][gnms_pkg::WSZ];
  logic           e2_q;
  logic [9:0]     col2_q;
  logic [11:0]    row2_q;
  logic [AW-1:0]  ccol;

  assign ccol = col1_q - AW'(gnms_pkg::R);

  // stage 2: compares and products on the window
  gnms_pkg::pix_t ctr;
  logic signed [8:0] gx_abs, gy_abs;
  logic [7:0]  ax, ay;
  logic [31:0] ax_lo, ax_hi, ay_lo, ay_hi;
  logic [3:0]  near_beat;
  logic [7:0]  far_beat;
  logic signed [18:0] dot [8];

  assign ctr = win_q[gnms_pkg::R][gnms_pkg::R];
  assign gx_abs = ctr.gx[8] ? -ctr.gx : ctr.gx;
  assign gy_abs = ctr.gy[8] ? -ctr.gy : ctr.gy;
  assign ax = gx_abs[7:0];
  assign ay = gy_abs[7:0];
  assign ax_lo = 32'(ax) * gnms_pkg::TAN_LO;
  assign ax_hi = 32'(ax) * gnms_pkg::TAN_HI;
  assign ay_lo = 32'(ay) * gnms_pkg::TAN_LO;
  assign ay_hi = 32'(ay) * gnms_pkg::TAN_HI;

  for (genvar n = 0; n < 4; n++) begin : g_near
    localparam int NR = gnms_pkg::R + gnms_pkg::dir_dy(2 * n);
    localparam int NC = gnms_pkg::R + gnms_pkg::dir_dx(2 * n);
    assign near_beat[n] = gnms_pkg::beats(ctr.norm, win_q[NR][NC].norm,
                                          gnms_pkg::lex_pos(2 * n));
  end

  for (genvar m = 0; m < 8; m++) begin : g_far
    localparam int FR = gnms_pkg::R + gnms_pkg::dir_dy(m) * gnms_pkg::far_mul(m);
    localparam int FC = gnms_pkg::R + gnms_pkg::dir_dx(m) * gnms_pkg::far_mul(m);
    assign far_beat[m] = gnms_pkg::beats(ctr.norm, win_q[FR][FC].norm,
                                         gnms_pkg::lex_pos(m));
    assign dot[m] = 19'(ctr.gx) * 19'(win_q[FR][FC].gx)
                  + 19'(ctr.gy) * 19'(win_q[FR][FC].gy);
  end

  // stage 3: sector decision, push to queue
  logic        e3_q;
  logic [9:0]  col3_q;
  logic [11:0] row3_q;
  logic [7:0]  ax3_q, ay3_q;
  logic [31:0] ax_lo_q, ax_hi_q, ay_lo_q, ay_hi_q;
  logic        gxn_q, gyn_q;
  logic [3:0]  near_q;
  logic [7:0]  far_q;
  logic signed [18:0] dot_q [8];

  logic [31:0] axs, ays;
  logic [2:0]  oct;
  logic [4:0]  sec;
  logic [7:0]  dot_pos;

  assign axs = {ax3_q, 24'b0};
  assign ays = {ay3_q, 24'b0};

  always_comb begin
    if (ays < ax_lo_q) oct = 3'd0;
    else if (ays < ax_hi_q) oct = 3'd1;
    else if (axs > ay_hi_q) oct = 3'd2;
    else if (axs > ay_lo_q) oct = 3'd3;
    else oct = 3'd4;
    case ({gxn_q, gyn_q})
      2'b00:   sec = 5'(oct);
      2'b10:   sec = 5'd8 - 5'(oct);
      2'b11:   sec = 5'd8 + 5'(oct);
      default: sec = 5'd16 - 5'(oct);
    endcase
    for (int m = 0; m < 8; m++) begin
      dot_pos[m] = dot_q[m] > 19'sd0;
    end
  end

  assign push_o           = e3_q;
  assign item_o.col       = col3_q;
  assign item_o.row       = row3_q;
  assign item_o.sector    = sec[3:0];
  assign item_o.beat_near = near_q;
  assign item_o.beat_far  = far_q;
  assign item_o.dot_pos   = dot_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
      e1_q  <= 1'b0;
      e2_q  <= 1'b0;
      e3_q  <= 1'b0;
      byp_q <= 1'b0;
      for (int r = 0; r < gnms_pkg::WSZ; r++) begin
        for (int c = 0; c < gnms_pkg::WSZ; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      v1_q  <= accept;
      e1_q  <= accept & emit0;
      byp_q <= accept & v1_q & (col1_q == col0);
      e2_q  <= v1_q & e1_q;
      e3_q  <= e2_q;
      if (v1_q) begin
        for (int r = 0; r < gnms_pkg::WSZ; r++) begin
          for (int c = 0; c < gnms_pkg::WSZ - 1; c++) begin
            win_q[r][c] <= win_q[r][c+1];
          end
        end
        for (int r = 0; r < gnms_pkg::NLINES; r++) begin
          win_q[r][gnms_pkg::WSZ-1] <= ent[r];
        end
        win_q[gnms_pkg::WSZ-1][gnms_pkg::WSZ-1] <= px1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px1_q  <= px0;
      col1_q <= col0;
      row1_q <= row0;
    end
    if (v1_q) begin
      wdata_q <= wdata;
      col2_q  <= 10'(ccol);
      row2_q  <= row1_q - 12'(gnms_pkg::R);
    end
    col3_q  <= col2_q;
    row3_q  <= row2_q;
    ax3_q   <= ax;
    ay3_q   <= ay;
    ax_lo_q <= ax_lo;
    ax_hi_q <= ax_hi;
    ay_lo_q <= ay_lo;
    ay_hi_q <= ay_hi;
    gxn_q   <= ctr.gx[8];
    gyn_q   <= ctr.gy[8];
    near_q  <= near_beat;
    far_q   <= far_beat;
    for (int m = 0; m < 8; m++) begin
      dot_q[m] <= dot[m];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gnms_queue.sv @@
// gnms_queue: small register queue of classified centers between the
// front and back parts. Depends on gnms_pkg.
`default_nettype none

module gnms_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire gnms_pkg::item_t item_i,
  input  wire logic            pop_i,
  output      logic            valid_o,
  output      gnms_pkg::item_t item_o,
  output      logic [$clog2(gnms_pkg::QDEPTH+1)-1:0] level_o
);

  localparam int PW  = $clog2(gnms_pkg::QDEPTH);
  localparam int QLW = $clog2(gnms_pkg::QDEPTH + 1);

  gnms_pkg::item_t mem_q [gnms_pkg::QDEPTH];
  logic [PW-1:0]   wptr_q, rptr_q;
  logic [QLW-1:0]  cnt_q;
  logic            do_pop;

  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rptr_q];
  assign level_o = cnt_q;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + PW'(1);
      if (do_pop) rptr_q <= rptr_q + PW'(1);
      if (push_i && !do_pop) cnt_q <= cnt_q + QLW'(1);
      else if (!push_i && do_pop) cnt_q <= cnt_q - QLW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= item_i;
  end

endmodule

`default_nettype wire

@@ hw/rtl/gnms_back.sv @@
// gnms_back: applies the sector neighbor table to a classified center and
// holds the result in the output register. Depends on gnms_pkg.
`default_nettype none

module gnms_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire gnms_pkg::item_t item_i,
  output      logic            pop_o,
  input  wire logic            bright_line_i,
  output      logic            out_valid_o,
  input  wire logic            out_stall_i,
  output      logic [9:0]      center_col_o,
  output      logic [11:0]     center_row_o,
  output      logic            is_max_o
);

  logic [7:0] incl;
  logic       reject;
  logic       near_hit, far_hit;
  int         ms, mo;

  assign incl = gnms_pkg::incl_mask(item_i.sector);

  always_comb begin
    reject = 1'b0;
    for (int m = 0; m < 8; m++) begin
      ms = bright_line_i ? (m ^ 4) : m;
      mo = ms ^ 4;
      near_hit = (m % 2 == 0) &&
                 (item_i.beat_near[m >> 1] || item_i.beat_near[(m ^ 4) >> 1]);
      far_hit = item_i.beat_far[ms] || (item_i.dot_pos[mo] && item_i.beat_far[mo]);
      reject = reject | (incl[m] & (near_hit | far_hit));
    end
  end

  assign pop_o = q_valid_i & (~out_valid_o | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (pop_o) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      center_col_o <= item_i.col;
      center_row_o <= item_i.row;
      is_max_o     <= ~reject;
    end
  end

endmodule

`default_nettype wire
